>>> design/lstl_pkg.sv
// ----------------------------------------------------------------------------
// lstl_pkg: shared types and constants of the leap-second table lookup
// Table depth, command and status codes, the table entry and compare result.
// ----------------------------------------------------------------------------
package lstl_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_UTC    = 2'd1;
    localparam logic [1:0] CMD_TAI    = 2'd2;

    localparam logic [1:0] HINT_IN_LEAP = 2'b01;
    localparam logic [1:0] HINT_UNKNOWN = 2'b11;

    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_EMPTY   = 3'd1;
    localparam logic [2:0] STAT_AMBIG   = 3'd2;
    localparam logic [2:0] STAT_IGNORED = 3'd3;
    localparam logic [2:0] STAT_FULL    = 3'd4;

    typedef struct packed {
        logic [63:0] start;
        logic [7:0]  offset;
    } entry_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

endpackage

>>> design/lstl_table.sv
// ----------------------------------------------------------------------------
// lstl_table: entry storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lstl_table
    import lstl_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/lstl_cmp.sv
// ----------------------------------------------------------------------------
// lstl_cmp: shared compare unit
// Form the reference second of an entry for the command, compare the time.
// ----------------------------------------------------------------------------
module lstl_cmp
    import lstl_pkg::*;
(
    input  logic [1:0]  cmd,
    input  logic [63:0] time_seconds,
    input  entry_t      entry,
    output cmp_res_t    res
);

    logic [8:0]  off_m1;
    logic [63:0] addend;
    logic [63:0] ref_sec;

    // insert: newest start; UTC: start - 1; TAI: start - 1 + offset
    assign off_m1 = {1'b0, entry.offset} - 9'd1;

    always_comb begin
        case (cmd)
            CMD_UTC: addend = '1;
            CMD_TAI: addend = {{55{off_m1[8]}}, off_m1};
            default: addend = '0;
        endcase
    end

    assign ref_sec = entry.start + addend;
    assign res.gt  = time_seconds > ref_sec;
    assign res.eq  = time_seconds == ref_sec;

endmodule

>>> design/leap_second_table_lookup.sv
// ----------------------------------------------------------------------------
// leap_second_table_lookup: leap-second table with UTC/TAI offset lookup
// Insert entries newest last, answer UTC and TAI queries newest first.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser
//  s_       | in  | time_seconds[63:0] leap_hint[65:64]     | command[1:0]
//           |     | offset_in[73:66], zero pad to 80 bits   |
//  m_       | out | status[2:0] offset_out[10:3]            | -
//           |     | in_leap[11], zero pad to 16 bits        |
//
// One beat at a time: an insert goes load, walk, send (into an empty table it
// writes in load, no walk); a query walks the table newest first, feeding one
// table entry per cycle from the single read port into the shared compare
// unit. Unused commands and empty-table queries go straight to send. Reset
// clears the state and entry count only; the table itself needs no clearing.
// s_tready is low while a beat is in work or its result waits on m_tready.
// ----------------------------------------------------------------------------
module leap_second_table_lookup
    import lstl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // time_seconds, leap_hint, offset_in
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status, offset_out, in_leap
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_WALK = 4'b0100,
        S_SEND = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [63:0]      time_reg, time_next;
    logic [1:0]       hint_reg, hint_next;
    logic [7:0]       offin_reg, offin_next;
    logic [2:0]       stat_reg, stat_next;
    logic [7:0]       off_reg, off_next;
    logic             leap_reg, leap_next;

    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W-1:0] cnt_m1;
    entry_t           wr_data;
    entry_t           rd_data;
    cmp_res_t         cmp;

    assign cnt_m1          = cnt_reg - CNT_W'(1);
    assign wr_data.start   = time_reg;
    assign wr_data.offset  = offin_reg;

    lstl_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lstl_cmp u_cmp (
        .cmd          (cmd_reg),
        .time_seconds (time_reg),
        .entry        (rd_data),
        .res          (cmp)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        time_next  = time_reg;
        hint_next  = hint_reg;
        offin_next = offin_reg;
        stat_next  = stat_reg;
        off_next   = off_reg;
        leap_next  = leap_reg;
        wr_en      = 1'b0;
        rd_addr    = idx_reg - IDX_W'(1);

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    // capture the beat, preset a clear result
                    cmd_next   = s_tuser;
                    time_next  = s_tdata[63:0];
                    hint_next  = s_tdata[65:64];
                    offin_next = s_tdata[73:66];
                    stat_next  = STAT_OK;
                    off_next   = '0;
                    leap_next  = 1'b0;
                    case (s_tuser) inside
                        CMD_INSERT: state_next = S_LOAD;
                        CMD_UTC, CMD_TAI: begin
                            if (cnt_reg == '0) begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_SEND;
                            end else begin
                                state_next = S_LOAD;
                            end
                        end
                        default: state_next = S_SEND;
                    endcase
                end
            end
            S_LOAD: begin
                // fetch the newest entry
                rd_addr  = cnt_m1[IDX_W-1:0];
                idx_next = cnt_m1[IDX_W-1:0];
                if (cmd_reg == CMD_INSERT && cnt_reg == '0) begin
                    wr_en      = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_SEND;
                end else begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                // rd_data holds entry idx_reg; the next older one is in flight
                if (cmd_reg == CMD_INSERT) begin
                    if (!cmp.gt) begin
                        stat_next = STAT_IGNORED;
                    end else if (cnt_reg == CNT_W'(TABLE_ENTRIES)) begin
                        stat_next = STAT_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    state_next = S_SEND;
                end else if (cmp.gt) begin
                    off_next   = rd_data.offset;
                    state_next = S_SEND;
                end else if (cmp.eq && cmd_reg == CMD_TAI) begin
                    off_next   = rd_data.offset;
                    leap_next  = 1'b1;
                    state_next = S_SEND;
                end else if (cmp.eq && hint_reg == HINT_IN_LEAP) begin
                    off_next   = rd_data.offset;
                    state_next = S_SEND;
                end else if (cmp.eq && hint_reg == HINT_UNKNOWN) begin
                    stat_next  = STAT_AMBIG;
                    state_next = S_SEND;
                end else if (idx_reg == '0) begin
                    // before the oldest entry: offset stays zero
                    state_next = S_SEND;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            S_SEND: begin
                // hold the result until the sink takes it
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        cmd_reg   <= cmd_next;
        time_reg  <= time_next;
        hint_reg  <= hint_next;
        offin_reg <= offin_next;
        stat_reg  <= stat_next;
        off_reg   <= off_next;
        leap_reg  <= leap_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_SEND);
    assign m_tdata  = {4'b0, leap_reg, off_reg, stat_reg};

endmodule

>>> tb/leap_second_table_lookup_test.sv
// ----------------------------------------------------------------------------
// leap_second_table_lookup_test: self-checking bench of the leap-second table
// Drives insert, UTC and TAI beats with random gaps and output stalls, keeps
// its own copy of the table, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module leap_second_table_lookup_test;
    import lstl_pkg::*;

    // codes the package leaves out
    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam logic [1:0] HINT_NORMAL = 2'b00;
    localparam logic [1:0] HINT_SPARE  = 2'b10;

    localparam int USEFUL_BEATS = 1750;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] offset;
        logic       in_leap;
    } answer_t;

    // Mirror of the leap table plus the queue of answers still owed by the block.
    class leap_offset_scoreboard;
        logic [63:0] start_tab [TABLE_ENTRIES];
        logic [7:0]  offset_tab [TABLE_ENTRIES];
        int          entry_count;
        answer_t     expected_answers [$];
        int          mismatches;
        int          answers_seen;

        function new();
            entry_count  = 0;
            mismatches   = 0;
            answers_seen = 0;
        endfunction

        // Work out the answer to one beat; an accepted insert also grows the table.
        function answer_t predict_lookup(logic [1:0] cmd, logic [63:0] t_sec,
                                         logic [1:0] hint, logic [7:0] off);
            answer_t     ans;
            logic [63:0] leap_utc;
            logic [63:0] leap_tai;
            ans = '0;
            ans.status = STAT_OK;
            if (cmd == CMD_INSERT) begin
                if (entry_count > 0 && start_tab[entry_count - 1] >= t_sec) begin
                    ans.status = STAT_IGNORED;
                end else if (entry_count >= TABLE_ENTRIES) begin
                    ans.status = STAT_FULL;
                end else begin
                    start_tab[entry_count]  = t_sec;
                    offset_tab[entry_count] = off;
                    entry_count++;
                end
                return ans;
            end
            if (cmd != CMD_UTC && cmd != CMD_TAI)
                return ans;
            if (entry_count == 0) begin
                ans.status = STAT_EMPTY;
                return ans;
            end
            // newest first; the repeated UTC second is start - 1, all mod 2^64
            for (int k = entry_count - 1; k >= 0; k--) begin
                leap_utc = start_tab[k] - 64'd1;
                if (cmd == CMD_UTC) begin
                    if (t_sec > leap_utc || (t_sec == leap_utc && hint == HINT_IN_LEAP)) begin
                        ans.offset = offset_tab[k];
                        return ans;
                    end
                    if (t_sec == leap_utc && hint == HINT_UNKNOWN) begin
                        ans.status = STAT_AMBIG;
                        return ans;
                    end
                end else begin
                    leap_tai = leap_utc + {56'd0, offset_tab[k]};
                    if (t_sec >= leap_tai) begin
                        ans.offset  = offset_tab[k];
                        ans.in_leap = (t_sec == leap_tai);
                        return ans;
                    end
                end
            end
            return ans;
        endfunction

        function void note_beat(logic [1:0] cmd, logic [63:0] t_sec,
                                logic [1:0] hint, logic [7:0] off);
            expected_answers.push_back(predict_lookup(cmd, t_sec, hint, off));
        endfunction

        task report_mismatch(string what);
            // keep the log short when the block is badly off
            if (mismatches < 200)
                $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_answer(logic [15:0] beat);
            answer_t want;
            answer_t got;
            got.status  = beat[2:0];
            got.offset  = beat[10:3];
            got.in_leap = beat[11];
            if (expected_answers.size() == 0) begin
                report_mismatch($sformatf("result beat %h with nothing pending", beat));
                return;
            end
            want = expected_answers.pop_front();
            if (got.status != want.status)
                report_mismatch($sformatf("answer %0d status %0d, want %0d",
                                          answers_seen, got.status, want.status));
            if (got.offset != want.offset)
                report_mismatch($sformatf("answer %0d offset %0d, want %0d",
                                          answers_seen, got.offset, want.offset));
            if (got.in_leap != want.in_leap)
                report_mismatch($sformatf("answer %0d in_leap %0b, want %0b",
                                          answers_seen, got.in_leap, want.in_leap));
            answers_seen++;
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // time_seconds, leap_hint, offset_in
    logic [1:0]  s_tuser  = '0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // status, offset_out, in_leap

    leap_offset_scoreboard sb;
    bit                    steady = 1'b0;   // no gaps or stalls while set

    leap_second_table_lookup uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one beat after a random gap and hold it until it is taken.
    task automatic send_beat(input logic [1:0] cmd, input logic [63:0] t_sec,
                             input logic [1:0] hint, input logic [7:0] off);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, off, hint, t_sec};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(cmd, t_sec, hint, off);
    endtask

    // Drop valid and hold off until every pending answer has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_answers.size() != 0);
    endtask

    // Output side: ready runs broken by random stalls.
    initial begin
        @(posedge aclk);
        forever begin
            int stall;
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_answer(m_tdata);
    end

    initial begin
        int          useful;
        int          r;
        int          idx;
        bit          paused_mid;
        logic [1:0]  cmd;
        logic [63:0] t_sec;
        logic [63:0] newest;
        sb = new();
        paused_mid = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: both query kinds and the spare command
        send_beat(CMD_UTC, 64'd0, HINT_NORMAL, 8'd0);
        send_beat(CMD_TAI, '1, HINT_UNKNOWN, 8'hFF);
        send_beat(CMD_SPARE, rand64(), HINT_SPARE, 8'hA5);
        // entry at second zero: its leap second wraps to all ones
        send_beat(CMD_INSERT, 64'd0, HINT_NORMAL, 8'd255);
        send_beat(CMD_INSERT, 64'd0, HINT_NORMAL, 8'd1);
        send_beat(CMD_UTC, '1, HINT_UNKNOWN, 8'd0);
        send_beat(CMD_UTC, '1, HINT_IN_LEAP, 8'd0);
        send_beat(CMD_UTC, '1, HINT_NORMAL, 8'd0);
        send_beat(CMD_UTC, '1, HINT_SPARE, 8'd0);
        send_beat(CMD_UTC, 64'd0, HINT_NORMAL, 8'd0);
        // TAI leap second of that entry wraps to 0xFE
        send_beat(CMD_TAI, 64'hFE, HINT_NORMAL, 8'd0);
        send_beat(CMD_TAI, 64'hFF, HINT_NORMAL, 8'd0);
        send_beat(CMD_TAI, 64'hFD, HINT_NORMAL, 8'd0);
        // second entry, an older one that is refused, then its leap second
        send_beat(CMD_INSERT, 64'd1000, HINT_NORMAL, 8'd37);
        send_beat(CMD_INSERT, 64'd500, HINT_NORMAL, 8'd9);
        send_beat(CMD_UTC, 64'd999, HINT_UNKNOWN, 8'd0);
        send_beat(CMD_UTC, 64'd999, HINT_NORMAL, 8'd0);
        send_beat(CMD_UTC, 64'd999, HINT_IN_LEAP, 8'd0);
        send_beat(CMD_UTC, 64'd1000, HINT_NORMAL, 8'd0);
        send_beat(CMD_TAI, 64'd1036, HINT_NORMAL, 8'd0);
        send_beat(CMD_TAI, 64'd1037, HINT_NORMAL, 8'd0);
        send_beat(CMD_TAI, 64'd1035, HINT_NORMAL, 8'd0);
        send_beat(CMD_SPARE, 64'd0, HINT_IN_LEAP, 8'd0);
        wait_drained();

        useful = 0;
        while (useful < USEFUL_BEATS) begin
            steady = (useful >= 600 && useful < 750);
            if (useful >= 1100 && !paused_mid) begin
                wait_drained();
                paused_mid = 1'b1;
            end
            newest = sb.start_tab[sb.entry_count - 1];
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_beat(CMD_SPARE, rand64(), 2'($urandom), 8'($urandom));
            end else if (r < 6) begin
                // stale insert: not newer than the newest entry
                send_beat(CMD_INSERT, newest - 64'($urandom_range(0, 5)),
                          2'($urandom), 8'($urandom));
            end else if (r < 12) begin
                // grow the table; the last slot goes near the top of the range
                if (sb.entry_count == TABLE_ENTRIES - 1)
                    t_sec = 64'hFFFF_FFFF_FFFF_FF00;
                else if (sb.entry_count == TABLE_ENTRIES)
                    t_sec = newest + 64'($urandom_range(1, 255));
                else if ($urandom_range(0, 9) < 4)
                    t_sec = newest + 64'($urandom_range(1, 3));
                else
                    t_sec = newest + (rand64() >> 7) + 64'd1;
                send_beat(CMD_INSERT, t_sec, 2'($urandom), 8'($urandom));
                useful++;
            end else begin
                cmd = $urandom_range(0, 1) ? CMD_UTC : CMD_TAI;
                if ($urandom_range(0, 9) < 2) begin
                    t_sec = rand64();
                end else begin
                    // land within two seconds of some entry's UTC or TAI leap second
                    idx = $urandom_range(0, sb.entry_count - 1);
                    t_sec = sb.start_tab[idx] - 64'd1;
                    if ($urandom_range(0, 1))
                        t_sec = t_sec + {56'd0, sb.offset_tab[idx]};
                    t_sec = t_sec + 64'($urandom_range(0, 4)) - 64'd2;
                end
                send_beat(cmd, t_sec, 2'($urandom), 8'($urandom));
                useful++;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
